>>> rtl/core/srrw_pkg.sv
// Shared widths, codes and types of the selective-repeat reorder window.
package srrw_pkg;

	localparam int REQ_TYPE_W = 2;
	localparam int PKT_SEQ_W  = 32;
	localparam int LEN_W      = 11;
	localparam int KIND_W     = 2;
	localparam int SLOT_W     = 4;
	localparam int WIN_CFG_W  = 5;

	localparam int DEF_MAX_WINDOW = 16;
	localparam int DEF_SEQ_BITS   = 32;

	localparam logic [WIN_CFG_W-1:0] WIN_RESET = 5'd16;

	// event kinds; anything else counts as corrupt
	localparam logic [REQ_TYPE_W-1:0] REQ_DATA = 2'd0;
	localparam logic [REQ_TYPE_W-1:0] REQ_END  = 2'd2;

	typedef enum logic [KIND_W-1:0] {
		KIND_ACK      = 2'd0,
		KIND_DELIVER  = 2'd1,
		KIND_FINISHED = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t                kind;
		logic [PKT_SEQ_W-1:0] seq;
		logic [SLOT_W-1:0]    slot;
		logic [LEN_W-1:0]     len;
		logic                 last;
	} res_t;

	typedef struct packed {
		logic put;
		logic flush;
	} out_cmd_t;

	typedef struct packed {
		logic can_put;
		logic can_flush;
		logic hold_vld;
	} out_stat_t;

endpackage

>>> rtl/core/srrw_req_if.sv
// Header event channel: valid/ready plus the event fields.
interface srrw_req_if;
	import srrw_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [REQ_TYPE_W-1:0] req_type;
	logic [PKT_SEQ_W-1:0]  packet_seq;
	logic [LEN_W-1:0]      payload_length;

	modport source (output valid, req_type, packet_seq, payload_length, input ready);
	modport sink   (input valid, req_type, packet_seq, payload_length, output ready);
endinterface

>>> rtl/core/srrw_res_if.sv
// Result channel: valid/ready plus the result fields.
interface srrw_res_if;
	import srrw_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [KIND_W-1:0]    result_kind;
	logic [PKT_SEQ_W-1:0] result_seq;
	logic [SLOT_W-1:0]    result_slot;
	logic [LEN_W-1:0]     result_length;
	logic                 last;

	modport source (output valid, result_kind, result_seq, result_slot, result_length, last,
		input ready);
	modport sink   (input valid, result_kind, result_seq, result_slot, result_length, last,
		output ready);
endinterface

>>> rtl/core/srrw_slot_mem.sv
// Slot store: one write port, one registered read port.
module srrw_slot_mem #(
	parameter int DEPTH  = 16,
	parameter int ADDR_W = 4,
	parameter int DATA_W = 43
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/core/srrw_out_stage.sv
// Result hold register and output register; sets last once the item is done.
module srrw_out_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  srrw_pkg::out_cmd_t  cmd,
	input  srrw_pkg::res_t      cand,
	output srrw_pkg::out_stat_t stat,
	srrw_res_if.source          res
);
	import srrw_pkg::*;

	logic out_vld_q;
	logic hold_vld_q;
	res_t out_q;
	res_t hold_q;
	logic o_free;
	logic do_put;
	logic do_flush;

	assign o_free         = !out_vld_q || res.ready;
	assign stat.can_put   = !hold_vld_q || o_free;
	assign stat.can_flush = o_free;
	assign stat.hold_vld  = hold_vld_q;

	assign do_put   = cmd.put && stat.can_put;
	assign do_flush = cmd.flush && o_free && hold_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			hold_vld_q <= 1'b0;
		end else if (do_flush) begin
			out_vld_q  <= 1'b1;
			hold_vld_q <= 1'b0;
		end else if (do_put) begin
			hold_vld_q <= 1'b1;
			if (hold_vld_q) begin
				out_vld_q <= 1'b1;
			end else if (res.ready) begin
				out_vld_q <= 1'b0;
			end
		end else if (res.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	// a held result goes out only once its successor (or the end) is known
	always_ff @(posedge clk) begin
		if (do_flush) begin
			out_q <= '{kind: hold_q.kind, seq: hold_q.seq, slot: hold_q.slot,
				len: hold_q.len, last: 1'b1};
		end else if (do_put) begin
			if (hold_vld_q) begin
				out_q <= '{kind: hold_q.kind, seq: hold_q.seq, slot: hold_q.slot,
					len: hold_q.len, last: 1'b0};
			end
			hold_q <= cand;
		end
	end

	assign res.valid         = out_vld_q;
	assign res.result_kind   = out_q.kind;
	assign res.result_seq    = out_q.seq;
	assign res.result_slot   = out_q.slot;
	assign res.result_length = out_q.len;
	assign res.last          = out_q.last;

	a_flush_has_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush |-> hold_vld_q)
		else $error("flush requested with no held result");

	a_put_moves_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(do_put && hold_vld_q) |=> (out_vld_q && !out_q.last))
		else $error("held result not moved out as non-final");

endmodule

>>> rtl/core/srrw_seq.sv
// Sequencer: slot scans through one shared sequence comparator.
module srrw_seq #(
	parameter int MAX_WINDOW = 16,
	parameter int SEQ_BITS   = 32,
	parameter int IDX_W      = 4,
	parameter int CNT_W      = 5
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [CNT_W-1:0]                     eff_w,
	srrw_req_if.sink                             req,
	output logic                                 mem_we,
	output logic [IDX_W-1:0]                     mem_waddr,
	output logic [SEQ_BITS+srrw_pkg::LEN_W-1:0]  mem_wdata,
	output logic [IDX_W-1:0]                     mem_raddr,
	input  logic [SEQ_BITS+srrw_pkg::LEN_W-1:0]  mem_rdata,
	output srrw_pkg::out_cmd_t                   cmd,
	output srrw_pkg::res_t                       cand,
	input  srrw_pkg::out_stat_t                  stat
);
	import srrw_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_DUP   = 6'b000010,
		ST_STORE = 6'b000100,
		ST_REL   = 6'b001000,
		ST_PUT   = 6'b010000,
		ST_FLUSH = 6'b100000
	} state_t;

	state_t                  state_q;
	state_t                  ret_q;
	logic [MAX_WINDOW-1:0]   valid_q;
	logic [SEQ_BITS-1:0]     exp_q;
	logic [SEQ_BITS-1:0]     pkt_seq_q;
	logic [LEN_W-1:0]        pkt_len_q;
	logic                    end_q;
	logic [CNT_W-1:0]        scan_q;
	logic [IDX_W-1:0]        idx_s1;
	logic                    vld_s1;
	logic [IDX_W-1:0]        free_q;
	logic                    free_fnd_q;
	res_t                    cand_q;

	logic [SEQ_BITS-1:0] in_seq;
	logic [SEQ_BITS-1:0] seq_gap;
	logic                in_win;
	logic                scanning;
	logic [SEQ_BITS-1:0] key;
	logic [SEQ_BITS-1:0] rd_seq;
	logic [LEN_W-1:0]    rd_len;
	logic                hit_s1;
	logic                scan_more;
	logic                scan_issue;
	logic                scan_done;
	logic [IDX_W-1:0]    scan_idx;
	logic                take_free;

	assign in_seq   = req.packet_seq[SEQ_BITS-1:0];
	assign seq_gap  = in_seq - exp_q;
	assign in_win   = seq_gap < SEQ_BITS'(eff_w);

	assign scanning  = (state_q == ST_DUP) || (state_q == ST_REL);
	assign key       = (state_q == ST_DUP) ? pkt_seq_q : exp_q;
	assign rd_seq    = mem_rdata[SEQ_BITS-1:0];
	assign rd_len    = mem_rdata[SEQ_BITS +: LEN_W];
	// the shared comparator
	assign hit_s1    = vld_s1 && valid_q[idx_s1] && (rd_seq == key);
	assign scan_more = scan_q < eff_w;
	assign scan_issue = scanning && !hit_s1 && scan_more;
	assign scan_done  = scanning && !vld_s1 && !scan_more;
	assign scan_idx   = scan_q[IDX_W-1:0];
	assign take_free  = (state_q == ST_DUP) && scan_issue && !valid_q[scan_idx] && !free_fnd_q;

	assign mem_raddr = scan_idx;
	assign mem_we    = (state_q == ST_STORE);
	assign mem_waddr = free_q;
	assign mem_wdata = {pkt_len_q, pkt_seq_q};

	assign req.ready = (state_q == ST_IDLE);
	assign cmd.put   = (state_q == ST_PUT);
	assign cmd.flush = (state_q == ST_FLUSH);
	assign cand      = cand_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			ret_q      <= ST_IDLE;
			valid_q    <= '0;
			exp_q      <= '0;
			end_q      <= 1'b0;
			scan_q     <= '0;
			vld_s1     <= 1'b0;
			free_fnd_q <= 1'b0;
		end else begin
			vld_s1 <= scan_issue;
			if (scan_issue) begin
				scan_q <= scan_q + CNT_W'(1);
			end
			if (take_free) begin
				free_fnd_q <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						scan_q     <= '0;
						free_fnd_q <= 1'b0;
						end_q      <= (req.req_type == REQ_END);
						if (req.req_type == REQ_END) begin
							state_q <= ST_REL;
						end else if ((req.req_type == REQ_DATA) && in_win) begin
							state_q <= ST_DUP;
						end
					end
				end
				ST_DUP: begin
					if (hit_s1) begin
						ret_q   <= ST_FLUSH;
						state_q <= ST_PUT;
					end else if (scan_done) begin
						state_q <= free_fnd_q ? ST_STORE : ST_IDLE;
					end
				end
				ST_STORE: begin
					valid_q[free_q] <= 1'b1;
					ret_q           <= ST_REL;
					state_q         <= ST_PUT;
				end
				ST_REL: begin
					if (hit_s1) begin
						valid_q[idx_s1] <= 1'b0;
						exp_q           <= exp_q + SEQ_BITS'(1);
						ret_q           <= ST_REL;
						state_q         <= ST_PUT;
					end else if (scan_done) begin
						if (end_q) begin
							valid_q <= '0;
							exp_q   <= '0;
							ret_q   <= ST_FLUSH;
							state_q <= ST_PUT;
						end else begin
							state_q <= ST_FLUSH;
						end
					end
				end
				ST_PUT: begin
					if (stat.can_put) begin
						scan_q  <= '0;
						state_q <= ret_q;
					end
				end
				ST_FLUSH: begin
					if (stat.can_flush) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= scan_idx;
		if (take_free) begin
			free_q <= scan_idx;
		end
		if ((state_q == ST_IDLE) && req.valid) begin
			pkt_seq_q <= in_seq;
			pkt_len_q <= req.payload_length;
		end
		case (state_q)
			ST_DUP: begin
				if (hit_s1) begin
					cand_q <= '{kind: KIND_ACK, seq: PKT_SEQ_W'(pkt_seq_q),
						slot: SLOT_W'(idx_s1), len: '0, last: 1'b0};
				end
			end
			ST_STORE: begin
				cand_q <= '{kind: KIND_ACK, seq: PKT_SEQ_W'(pkt_seq_q),
					slot: SLOT_W'(free_q), len: '0, last: 1'b0};
			end
			ST_REL: begin
				if (hit_s1) begin
					cand_q <= '{kind: KIND_DELIVER, seq: PKT_SEQ_W'(rd_seq),
						slot: SLOT_W'(idx_s1), len: rd_len, last: 1'b0};
				end else if (scan_done) begin
					cand_q <= '{kind: KIND_FINISHED, seq: PKT_SEQ_W'(exp_q),
						slot: '0, len: '0, last: 1'b0};
				end
			end
			default: begin
			end
		endcase
	end

	a_store_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STORE) |-> !valid_q[free_q])
		else $error("store into a held slot");

	a_exp_step: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_REL) && hit_s1) |=> (exp_q == $past(exp_q) + SEQ_BITS'(1)))
		else $error("expected sequence did not advance on delivery");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !stat.hold_vld)
		else $error("result left in hold register at idle");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (CNT_W'(idx_s1) < eff_w))
		else $error("slot compared outside the window");

endmodule

>>> rtl/core/selective_repeat_reorder_window_core.sv
// Selective-repeat reorder window: top level with the window register.
//
// Takes one packet header event per transfer on req and answers on res with
// acknowledges, in-order deliveries and a finished marker; last flags the
// final result of each event. An event is taken only while the sequencer is
// idle. A corrupt event, or a data event outside [expected, expected + W),
// gives nothing. Otherwise every slot search is a walk of the slot memory's
// single read port, one slot per cycle through the one sequence comparator.
// A stored packet goes through the duplicate search, the store plus its
// acknowledge, a search and hand-off for each in-order delivery, the closing
// search and the final hand-off; an end event skips the duplicate search and
// the store. W is the effective window (the window register, 0 read as 1,
// capped at MAX_WINDOW). Slot occupancy lives in flip-flops, so no clearing
// pass runs after reset. Results queue in a hold register and an output
// register, so a stalled sink only stops the sequencer when both are full.
// The window register is written through cfg_we/cfg_wdata and must only
// change while idle.
module selective_repeat_reorder_window_core #(
	parameter int MAX_WINDOW = srrw_pkg::DEF_MAX_WINDOW,
	parameter int SEQ_BITS   = srrw_pkg::DEF_SEQ_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [srrw_pkg::WIN_CFG_W-1:0] cfg_wdata,
	srrw_req_if.sink                       req,
	srrw_res_if.source                     res
);
	import srrw_pkg::*;

	// slot index and a counter that can also hold the window itself
	localparam int IDX_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
	localparam int DATA_W = SEQ_BITS + LEN_W;

	logic [WIN_CFG_W-1:0] win_cfg_q;
	logic [CNT_W-1:0]     eff_w;

	logic              mem_we;
	logic [IDX_W-1:0]  mem_waddr;
	logic [DATA_W-1:0] mem_wdata;
	logic [IDX_W-1:0]  mem_raddr;
	logic [DATA_W-1:0] mem_rdata;

	out_cmd_t  cmd;
	out_stat_t stat;
	res_t      cand;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_cfg_q <= WIN_RESET;
		end else if (cfg_we) begin
			win_cfg_q <= cfg_wdata;
		end
	end

	// effective window: zero reads as one, clamp to the slot count
	always_comb begin
		if (win_cfg_q == '0) begin
			eff_w = CNT_W'(1);
		end else if (int'(win_cfg_q) > MAX_WINDOW) begin
			eff_w = CNT_W'(MAX_WINDOW);
		end else begin
			eff_w = CNT_W'(win_cfg_q);
		end
	end

	srrw_seq #(
		.MAX_WINDOW (MAX_WINDOW),
		.SEQ_BITS   (SEQ_BITS),
		.IDX_W      (IDX_W),
		.CNT_W      (CNT_W)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.eff_w     (eff_w),
		.req       (req),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata),
		.cmd       (cmd),
		.cand      (cand),
		.stat      (stat)
	);

	// sequence and length of each slot; occupancy is kept in the sequencer
	srrw_slot_mem #(
		.DEPTH  (MAX_WINDOW),
		.ADDR_W (IDX_W),
		.DATA_W (DATA_W)
	) u_slot_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	srrw_out_stage u_out_stage (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.cand   (cand),
		.stat   (stat),
		.res    (res)
	);

endmodule
